// ===== hdl/sliding_window_histogram_macros.svh =====
// Assertion helpers used by the sliding_window_histogram RTL.
`ifndef SLIDING_WINDOW_HISTOGRAM_MACROS_SVH
`define SLIDING_WINDOW_HISTOGRAM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWH_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swh_pkg.sv =====
package swh_pkg;

  localparam int NUM_BOUNDS = 6;
  localparam int TIME_SLOTS = 4;

  localparam int NBUCKETS   = NUM_BOUNDS + 1;
  localparam int BKT_W      = $clog2(NBUCKETS);
  localparam int SLOT_W     = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1;
  localparam int ADDR_W     = SLOT_W + BKT_W;
  localparam int BKT_DEPTH  = 1 << ADDR_W;
  localparam int SLOT_DEPTH = 1 << SLOT_W;
  localparam int BKT_SPAN   = 1 << BKT_W;
  // Widths of the collect accumulators: sums of 32-bit counts.
  localparam int CUM_W      = 32 + $clog2(NBUCKETS * TIME_SLOTS);
  localparam int TOT_W      = 32 + $clog2(TIME_SLOTS);

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_COLLECT = 2'd2;

  localparam logic [1:0] KIND_BUCKET = 2'd0;
  localparam logic [1:0] KIND_SUM    = 2'd1;
  localparam logic [1:0] KIND_COUNT  = 2'd2;

  localparam logic [2:0] REG_BOUND_0       = 3'd0;
  localparam logic [2:0] REG_BOUNDS_USED   = 3'd6;
  localparam logic [2:0] REG_WINDOW_ENABLE = 3'd7;

  typedef logic [NUM_BOUNDS-1:0][31:0] swh_bounds_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  rd_slot;
    logic [BKT_W-1:0]   rd_bkt;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_slot;
    logic [BKT_W-1:0]   wr_bkt;
    logic [31:0]        wr_count;
    logic [63:0]        wr_sum;
    logic [31:0]        wr_scount;
    logic               clr_en;
    logic [SLOT_W-1:0]  clr_slot;
  } swh_mem_req_t;

  typedef struct packed {
    logic [31:0] bkt_count;
    logic [63:0] sum;
    logic [31:0] scount;
  } swh_mem_rsp_t;

  function automatic logic [31:0] cnt_inc(input logic [31:0] c);
    return (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

  // Signed 64-bit add that clamps at the signed limits.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== hdl/swh_classify.sv =====
module swh_classify (
  input  logic [31:0]                sample,
  input  swh_pkg::swh_bounds_t       bounds,
  input  logic [swh_pkg::BKT_W-1:0]  nb,
  output logic [swh_pkg::BKT_W-1:0]  bkt
);
  import swh_pkg::*;

  // Lowest bucket whose inclusive bound holds the sample wins; else overflow.
  always_comb begin
    bkt = nb;
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if ((BKT_W'(i) < nb) && ($signed(sample) <= $signed(bounds[i]))) begin
        bkt = BKT_W'(i);
      end
    end
  end

endmodule

// ===== hdl/swh_slot_mem.sv =====
module swh_slot_mem (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swh_pkg::swh_mem_req_t req,
  output swh_pkg::swh_mem_rsp_t rsp
);
  import swh_pkg::*;

  logic [31:0] bkt_mem  [BKT_DEPTH];
  logic [63:0] sum_mem  [SLOT_DEPTH];
  logic [31:0] scnt_mem [SLOT_DEPTH];

  // Entries that were never written since reset or since their slot was
  // retired read as zero.
  logic [SLOT_DEPTH-1:0][BKT_SPAN-1:0] bkt_vld_r;
  logic [SLOT_DEPTH-1:0]               slot_vld_r;

  logic [31:0] bkt_q_r;
  logic [63:0] sum_q_r;
  logic [31:0] scnt_q_r;
  logic        bkt_vq_r;
  logic        slot_vq_r;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  assign rd_addr = {req.rd_slot, req.rd_bkt};
  assign wr_addr = {req.wr_slot, req.wr_bkt};

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      bkt_mem[wr_addr]      <= req.wr_count;
      sum_mem[req.wr_slot]  <= req.wr_sum;
      scnt_mem[req.wr_slot] <= req.wr_scount;
    end
    bkt_q_r  <= bkt_mem[rd_addr];
    sum_q_r  <= sum_mem[req.rd_slot];
    scnt_q_r <= scnt_mem[req.rd_slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkt_vld_r  <= '0;
      slot_vld_r <= '0;
      bkt_vq_r   <= 1'b0;
      slot_vq_r  <= 1'b0;
    end else begin
      if (req.clr_en) begin
        bkt_vld_r[req.clr_slot]  <= '0;
        slot_vld_r[req.clr_slot] <= 1'b0;
      end
      if (req.wr_en) begin
        bkt_vld_r[req.wr_slot][req.wr_bkt] <= 1'b1;
        slot_vld_r[req.wr_slot]            <= 1'b1;
      end
      bkt_vq_r  <= bkt_vld_r[req.rd_slot][req.rd_bkt];
      slot_vq_r <= slot_vld_r[req.rd_slot];
    end
  end

  assign rsp.bkt_count = bkt_vq_r  ? bkt_q_r  : '0;
  assign rsp.sum       = slot_vq_r ? sum_q_r  : '0;
  assign rsp.scount    = slot_vq_r ? scnt_q_r : '0;

endmodule

// ===== hdl/sliding_window_histogram.sv =====
// Sliding-window histogram. Requests on the in_ channel are observe (0),
// tick (1) or collect (2), selected by in_tuser. In an observe, the slot and
// bucket entries are read from the registered-read state memory in the
// accept cycle and written back in the next, while in_tready is low. A tick
// is done in its accept cycle; retiring a slot only drops its valid bits, so
// there is no clearing pass after reset or on rotation. A collect walks the
// bucket memory entry by entry and then the slot totals the same way, and
// in_tready stays low until its last result is loaded into the output
// register. Results leave through that register, so observes and ticks are
// taken while a collect result still waits. Configuration is written at any
// time through cfg_, but only while the block is idle is the effect defined.
// Neither input channel is ready while rst_n is low.
`include "sliding_window_histogram_macros.svh"

module sliding_window_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [2:0] bucket_index, [66:3] amount, [71:67] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import swh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OBS_WR,
    ST_C_BRD,
    ST_C_BACC,
    ST_C_BEMIT,
    ST_C_SRD,
    ST_C_SACC,
    ST_C_SEMIT,
    ST_C_CEMIT
  } state_t;

  // Configuration registers.
  swh_bounds_t bounds_r;
  logic [2:0]  bounds_used_r;
  logic        window_en_r;

  state_t             state_r,     state_nxt;
  logic [SLOT_W-1:0]  cur_slot_r,  cur_slot_nxt;
  logic               running_r,   running_nxt;
  logic [31:0]        sample_r,    sample_nxt;
  logic [BKT_W-1:0]   obs_bkt_r,   obs_bkt_nxt;
  logic [BKT_W-1:0]   bkt_i_r,     bkt_i_nxt;
  logic [SLOT_W-1:0]  slot_t_r,    slot_t_nxt;
  logic [CUM_W-1:0]   cum_r,       cum_nxt;
  logic [63:0]        sum_r,       sum_nxt;
  logic [TOT_W-1:0]   tot_r,       tot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r,  out_kind_nxt;
  logic [2:0]         out_idx_r,   out_idx_nxt;
  logic [63:0]        out_amt_r,   out_amt_nxt;
  logic               out_last_r,  out_last_nxt;

  logic [2:0]         nb3;
  logic [BKT_W-1:0]   nb;
  logic [BKT_W-1:0]   cls_bkt;
  logic [SLOT_W-1:0]  next_slot;
  logic               last_slot;
  logic               out_free;
  swh_mem_req_t       mem_req;
  swh_mem_rsp_t       mem_rsp;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r      <= '0;
      bounds_used_r <= 3'(NUM_BOUNDS);
      window_en_r   <= 1'b0;
    end else if (cfg_valid) begin
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        if (cfg_index == REG_BOUND_0 + 3'(i)) begin
          bounds_r[i] <= cfg_data;
        end
      end
      if (cfg_index == REG_BOUNDS_USED) begin
        bounds_used_r <= cfg_data[2:0];
      end
      if (cfg_index == REG_WINDOW_ENABLE) begin
        window_en_r <= cfg_data[0];
      end
    end
  end

  always_comb begin
    if (bounds_used_r == 3'd0) begin
      nb3 = 3'd1;
    end else if (bounds_used_r > 3'(NUM_BOUNDS)) begin
      nb3 = 3'(NUM_BOUNDS);
    end else begin
      nb3 = bounds_used_r;
    end
  end

  assign nb = nb3[BKT_W-1:0];

  swh_classify u_classify (
    .sample (in_tdata),
    .bounds (bounds_r),
    .nb     (nb),
    .bkt    (cls_bkt)
  );

  swh_slot_mem u_slot_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rsp   (mem_rsp)
  );

  assign next_slot = (cur_slot_r == SLOT_W'(TIME_SLOTS - 1)) ? '0 : cur_slot_r + 1'b1;
  assign last_slot = (slot_t_r == SLOT_W'(TIME_SLOTS - 1));
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = rst_n && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cur_slot_nxt  = cur_slot_r;
    running_nxt   = running_r;
    sample_nxt    = sample_r;
    obs_bkt_nxt   = obs_bkt_r;
    bkt_i_nxt     = bkt_i_r;
    slot_t_nxt    = slot_t_r;
    cum_nxt       = cum_r;
    sum_nxt       = sum_r;
    tot_nxt       = tot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_amt_nxt   = out_amt_r;
    out_last_nxt  = out_last_r;

    mem_req           = '0;
    mem_req.rd_slot   = cur_slot_r;
    mem_req.rd_bkt    = cls_bkt;
    mem_req.wr_slot   = cur_slot_r;
    mem_req.wr_bkt    = obs_bkt_r;
    mem_req.wr_count  = cnt_inc(mem_rsp.bkt_count);
    mem_req.wr_sum    = sat_add64(mem_rsp.sum, {{32{sample_r[31]}}, sample_r});
    mem_req.wr_scount = cnt_inc(mem_rsp.scount);
    mem_req.clr_slot  = next_slot;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            CMD_OBSERVE: begin
              // The memory read for this observe is issued in this cycle.
              sample_nxt  = in_tdata;
              obs_bkt_nxt = cls_bkt;
              if (window_en_r) begin
                running_nxt = 1'b1;
              end
              state_nxt = ST_OBS_WR;
            end
            CMD_TICK: begin
              if (window_en_r && running_r) begin
                cur_slot_nxt   = next_slot;
                mem_req.clr_en = 1'b1;
              end
            end
            CMD_COLLECT: begin
              bkt_i_nxt  = '0;
              slot_t_nxt = '0;
              cum_nxt    = '0;
              sum_nxt    = '0;
              tot_nxt    = '0;
              state_nxt  = ST_C_BRD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_OBS_WR: begin
        mem_req.wr_en = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_C_BRD: begin
        mem_req.rd_slot = slot_t_r;
        mem_req.rd_bkt  = bkt_i_r;
        state_nxt       = ST_C_BACC;
      end
      ST_C_BACC: begin
        cum_nxt = cum_r + CUM_W'(mem_rsp.bkt_count);
        if (last_slot) begin
          slot_t_nxt = '0;
          state_nxt  = ST_C_BEMIT;
        end else begin
          slot_t_nxt = slot_t_r + 1'b1;
          state_nxt  = ST_C_BRD;
        end
      end
      ST_C_BEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BUCKET;
          out_idx_nxt   = 3'(bkt_i_r);
          out_amt_nxt   = 64'(cum_r);
          out_last_nxt  = 1'b0;
          if (bkt_i_r == nb) begin
            state_nxt = ST_C_SRD;
          end else begin
            bkt_i_nxt = bkt_i_r + 1'b1;
            state_nxt = ST_C_BRD;
          end
        end
      end
      ST_C_SRD: begin
        mem_req.rd_slot = slot_t_r;
        state_nxt       = ST_C_SACC;
      end
      ST_C_SACC: begin
        // Slot 0 is added first and the sum clamps at every step.
        sum_nxt = sat_add64(sum_r, mem_rsp.sum);
        tot_nxt = tot_r + TOT_W'(mem_rsp.scount);
        if (last_slot) begin
          state_nxt = ST_C_SEMIT;
        end else begin
          slot_t_nxt = slot_t_r + 1'b1;
          state_nxt  = ST_C_SRD;
        end
      end
      ST_C_SEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SUM;
          out_idx_nxt   = 3'd0;
          out_amt_nxt   = sum_r;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_C_CEMIT;
        end
      end
      ST_C_CEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_COUNT;
          out_idx_nxt   = 3'd0;
          out_amt_nxt   = 64'(tot_r);
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_slot_r  <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_slot_r  <= cur_slot_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    obs_bkt_r  <= obs_bkt_nxt;
    bkt_i_r    <= bkt_i_nxt;
    slot_t_r   <= slot_t_nxt;
    cum_r      <= cum_nxt;
    sum_r      <= sum_nxt;
    tot_r      <= tot_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_amt_r  <= out_amt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_amt_r, out_idx_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `SWH_ASSERT_NEXT(a_obs_interlock, in_tvalid && in_tready && (in_tuser == CMD_OBSERVE), !in_tready, "new request taken during observe write-back")
  `SWH_ASSERT_SAME(a_clr_vs_wr, mem_req.clr_en, !mem_req.wr_en, "slot retired during a write-back")
  `SWH_ASSERT_SAME(a_last_is_count, out_tvalid && out_tlast, out_tuser == KIND_COUNT, "last result is not the total count")

endmodule

// ===== verif/sliding_window_histogram_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_histogram_tb;
  import swh_pkg::*;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [31:0] INT_MIN32     = 32'h8000_0000;
  localparam logic [31:0] INT_MAX32     = 32'h7FFF_FFFF;
  localparam int          SETTLE_CYCLES = 100;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  bucket;
    logic [63:0] amount;
    logic        last;
  } readout_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Histogram state as the block should hold it.
  logic signed [31:0] hist_bounds [NUM_BOUNDS];
  logic [2:0]         hist_used;
  logic               hist_window;
  logic [31:0]        slot_counts [TIME_SLOTS][NBUCKETS];
  logic signed [63:0] slot_totals [TIME_SLOTS];
  logic [31:0]        slot_samples [TIME_SLOTS];
  int unsigned        live_slot;
  bit                 timer_on;

  readout_t pending_readouts[$];
  int       error_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_left = 0;

  sliding_window_histogram i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] sample
    .in_tuser   (in_tuser),   // [1:0] command
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [2:0] bucket_index, [66:3] amount, [71:67] zero
    .out_tuser  (out_tuser),  // [1:0] kind
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  task automatic reset_histogram();
    for (int i = 0; i < NUM_BOUNDS; i++) hist_bounds[i] = '0;
    hist_used = 3'(NUM_BOUNDS);
    hist_window = 1'b0;
    for (int t = 0; t < TIME_SLOTS; t++) begin
      for (int b = 0; b < NBUCKETS; b++) slot_counts[t][b] = '0;
      slot_totals[t] = '0;
      slot_samples[t] = '0;
    end
    live_slot = 0;
    timer_on = 1'b0;
  endtask

  // Updates the histogram for one accepted request and queues any readout.
  task automatic predict_request(input logic [1:0] cmd, input logic [31:0] sample);
    int          nb;
    int          bkt;
    logic [63:0] cum;
    logic [63:0] total;
    logic [63:0] sum_all;
    nb = (hist_used == 0) ? 1 : (hist_used > NUM_BOUNDS) ? NUM_BOUNDS : int'(hist_used);
    case (cmd)
      CMD_OBSERVE: begin
        if (hist_window) timer_on = 1'b1;
        slot_totals[live_slot] = clamp_add(slot_totals[live_slot],
                                           {{32{sample[31]}}, sample});
        slot_samples[live_slot] = bump(slot_samples[live_slot]);
        bkt = nb;
        for (int i = nb - 1; i >= 0; i--) begin
          if ($signed(sample) <= hist_bounds[i]) bkt = i;
        end
        slot_counts[live_slot][bkt] = bump(slot_counts[live_slot][bkt]);
      end
      CMD_TICK: begin
        if (hist_window && timer_on) begin
          live_slot = (live_slot + 1) % TIME_SLOTS;
          for (int b = 0; b < NBUCKETS; b++) slot_counts[live_slot][b] = '0;
          slot_totals[live_slot] = '0;
          slot_samples[live_slot] = '0;
        end
      end
      CMD_COLLECT: begin
        cum = '0;
        total = '0;
        sum_all = '0;
        for (int i = 0; i <= nb; i++) begin
          for (int t = 0; t < TIME_SLOTS; t++) cum += 64'(slot_counts[t][i]);
          pending_readouts.push_back('{KIND_BUCKET, 3'(i), cum, 1'b0});
        end
        for (int t = 0; t < TIME_SLOTS; t++) begin
          sum_all = clamp_add(sum_all, slot_totals[t]);
          total += 64'(slot_samples[t]);
        end
        pending_readouts.push_back('{KIND_SUM, 3'd0, sum_all, 1'b0});
        pending_readouts.push_back('{KIND_COUNT, 3'd0, total, 1'b1});
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] sample);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= sample;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(cmd, sample);
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender until every readout is back and any observe or tick
  // still in flight has had time to finish.
  task automatic wait_for_readouts();
    in_tvalid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers; only called while the block is idle.
  task automatic configure(input logic [NUM_BOUNDS-1:0][31:0] bounds,
                           input logic [2:0] used, input logic window);
    for (int r = 0; r < NUM_BOUNDS + 2; r++) begin
      cfg_valid <= 1'b1;
      if (r < NUM_BOUNDS) begin
        cfg_index <= REG_BOUND_0 + 3'(r);
        cfg_data  <= bounds[r];
      end else if (r == NUM_BOUNDS) begin
        cfg_index <= REG_BOUNDS_USED;
        cfg_data  <= ($urandom() & ~32'h7) | 32'(used);
      end else begin
        cfg_index <= REG_WINDOW_ENABLE;
        cfg_data  <= ($urandom() & ~32'h1) | 32'(window);
      end
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (r < NUM_BOUNDS) hist_bounds[r] = bounds[r];
      else if (r == NUM_BOUNDS) hist_used = used;
      else hist_window = window;
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [NUM_BOUNDS-1:0][31:0] make_bounds();
    logic [NUM_BOUNDS-1:0][31:0] b;
    logic [31:0]                 step;
    step = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 1 << 20);
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      b[i] = 32'($urandom_range(0, 2000)) - step * 3 + step * i;
    end
    return b;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return hist_bounds[$urandom_range(0, NUM_BOUNDS - 1)] + $urandom_range(0, 2) - 1;
      2: begin
        case ($urandom_range(0, 3))
          0: return INT_MIN32;
          1: return INT_MAX32;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($urandom_range(0, 200)) - 32'd100;
    endcase
  endfunction

  function automatic logic [1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 62) return CMD_OBSERVE;
    if (r < 80) return CMD_TICK;
    if (r < 96) return CMD_COLLECT;
    return CMD_UNUSED;
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_readouts
    readout_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readouts.size() == 0) begin
        $error("unexpected result: kind %0d, amount %0d", out_tuser,
               $signed(out_tdata[66:3]));
        error_count++;
      end else begin
        exp = pending_readouts.pop_front();
        if (out_tuser !== exp.kind) begin
          $error("kind: expected %0d, got %0d", exp.kind, out_tuser);
          error_count++;
        end
        if (out_tdata[2:0] !== exp.bucket) begin
          $error("bucket_index: expected %0d, got %0d", exp.bucket, out_tdata[2:0]);
          error_count++;
        end
        if (out_tdata[66:3] !== exp.amount) begin
          $error("amount: expected %0d, got %0d", $signed(exp.amount),
                 $signed(out_tdata[66:3]));
          error_count++;
        end
        if (out_tlast !== exp.last) begin
          $error("last: expected %0d, got %0d", exp.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Empty readout, extreme samples, and commands that must be ignored.
  task automatic test_reset_defaults();
    send_request(CMD_COLLECT, 32'h0);
    send_request(CMD_OBSERVE, INT_MIN32);
    send_request(CMD_OBSERVE, INT_MAX32);
    send_request(CMD_OBSERVE, 32'h0);
    send_request(CMD_OBSERVE, 32'h1);
    send_request(CMD_TICK, 32'h0);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    send_request(CMD_COLLECT, 32'h0);
    wait_for_readouts();
  endtask

  // Samples exactly on a bound, bounds_used outside its range, bounds out of order.
  task automatic test_bound_edges();
    configure({INT_MAX32, 32'd5000, 32'd100, 32'd0, -32'sd100, INT_MIN32}, 3'd0, 1'b0);
    send_request(CMD_OBSERVE, INT_MIN32);
    send_request(CMD_OBSERVE, -32'sd5);
    send_request(CMD_COLLECT, 32'h0);
    wait_for_readouts();
    configure({INT_MAX32, 32'd5000, -32'sd200, 32'd0, -32'sd100, INT_MIN32}, 3'd7, 1'b0);
    send_request(CMD_OBSERVE, 32'd100);
    send_request(CMD_OBSERVE, 32'd101);
    send_request(CMD_OBSERVE, -32'sd150);
    send_request(CMD_COLLECT, 32'h0);
    wait_for_readouts();
  endtask

  // Ticks before the first sample, a full wrap of the ring, then ticks while disabled.
  task automatic test_window_rotation();
    configure({INT_MAX32, 32'd5000, 32'd100, 32'd0, -32'sd100, INT_MIN32}, 3'd6, 1'b1);
    send_request(CMD_TICK, 32'h0);
    send_request(CMD_OBSERVE, 32'd7);
    send_request(CMD_TICK, 32'h0);
    send_request(CMD_OBSERVE, -32'sd7);
    repeat (3) send_request(CMD_TICK, 32'h0);
    send_request(CMD_COLLECT, 32'h0);
    wait_for_readouts();
    configure({INT_MAX32, 32'd5000, 32'd100, 32'd0, -32'sd100, INT_MIN32}, 3'd6, 1'b0);
    send_request(CMD_TICK, 32'h0);
    send_request(CMD_COLLECT, 32'h0);
    wait_for_readouts();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int count, input logic [2:0] used,
                                     input logic window);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    configure(make_bounds(), used, window);
    for (int n = 0; n < count; n++) send_request(pick_command(), pick_sample());
    wait_for_readouts();
  endtask

  // The receiver holds off long enough for pending readouts to back up into
  // the input while the sender keeps offering requests.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 9;
    configure(make_bounds(), 3'd6, 1'b1);
    hold_left = 400;
    for (int n = 0; n < 30; n++) begin
      send_request((n % 5 == 4) ? CMD_COLLECT : pick_command(), pick_sample());
    end
    wait_for_readouts();
  endtask

  initial begin
    reset_histogram();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_bound_edges();
    test_window_rotation();
    test_random_traffic(0, 0, 75, 3'd1, 1'b1);
    test_random_traffic(71, 0, 75, 3'd6, 1'b0);
    test_random_traffic(0, 71, 75, 3'($urandom_range(0, 7)), 1'b1);
    test_random_traffic(9, 9, 75, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    test_output_backpressure();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
